>>> hdl/ampcc_pkg.sv
// Shared types, constants and microcode table for the antagonist muscle co-contraction unit.
package ampcc_pkg;

  localparam int unsigned LenW    = 24;
  localparam int unsigned TgtW    = 23;
  localparam int unsigned TsW     = 24;
  localparam int unsigned GainW   = 16;
  localparam int unsigned DriveW  = 23;
  localparam int unsigned IntegW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;
  localparam int unsigned PcW     = 4;

  localparam logic [CfgIdxW-1:0] CFG_TGT_RIGHT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TGT_LEFT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMESTEP  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_BIAS      = 3'd6;

  localparam logic [TgtW-1:0]  TGT_RST       = 23'd0;
  localparam logic [TsW-1:0]   TIMESTEP_RST  = 24'd33554;
  localparam logic [GainW-1:0] PROP_GAIN_RST = 16'd12800;
  localparam logic [GainW-1:0] DERIV_GAIN_RST = 16'd2048;
  localparam logic [GainW-1:0] INTEG_GAIN_RST = 16'd2048;
  localparam logic [TgtW-1:0]  BIAS_RST      = 23'd6554;

  // Spindle velocity weight 0.05 in unsigned Q0.16.
  localparam logic [TsW-1:0]   SPINDLE_VEL_WEIGHT = 24'd3277;
  localparam logic [DriveW-1:0] DRIVE_MAX = 23'h7FFFFF;

  typedef enum logic [2:0] {
    OPA_NONE = 3'b001,
    OPA_ERR  = 3'b010,
    OPA_VEL  = 3'b100,
    OPA_INT  = 3'b000
  } opa_sel_t;

  typedef enum logic [2:0] {
    OPB_TS  = 3'd0,
    OPB_KP  = 3'd1,
    OPB_KD  = 3'd2,
    OPB_KI  = 3'd3,
    OPB_SPW = 3'd4
  } opb_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE  = 3'd0,
    WB_INTEG = 3'd1,
    WB_LEVSP = 3'd2,
    WB_INH   = 3'd3,
    WB_DRV   = 3'd4
  } wb_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_WAIT_IN  = 2'd1,
    JMP_WAIT_OUT = 2'd2,
    JMP_START    = 2'd3
  } jmp_t;

  typedef struct packed {
    opa_sel_t mul_a;
    opb_sel_t mul_b;
    logic     mul_left;
    acc_op_t  acc_op;
    wb_op_t   wb;
    logic     wb_left;
    jmp_t     jmp;
  } ctrl_t;

  typedef struct packed {
    logic in_go;
    logic out_free;
  } seq_cond_t;

  function automatic ctrl_t mk(opa_sel_t a, opb_sel_t b, logic ml, acc_op_t ac,
                               wb_op_t w, logic wl, jmp_t j);
    ctrl_t c;
    c.mul_a    = a;
    c.mul_b    = b;
    c.mul_left = ml;
    c.acc_op   = ac;
    c.wb       = w;
    c.wb_left  = wl;
    c.jmp      = j;
    return c;
  endfunction

  // One control word per step. The right muscle runs in steps 1 to 6, the left
  // muscle in steps 6 to 11; step 6 writes back the right side while it starts
  // the first multiply of the left side.
  function automatic ctrl_t ucode(logic [PcW-1:0] pc);
    ctrl_t c;
    unique case (pc)
      4'd0:  c = mk(OPA_NONE, OPB_TS,  1'b0, ACC_HOLD, WB_NONE,  1'b0, JMP_WAIT_IN);
      4'd1:  c = mk(OPA_ERR,  OPB_TS,  1'b0, ACC_HOLD, WB_NONE,  1'b0, JMP_NEXT);
      4'd2:  c = mk(OPA_ERR,  OPB_KP,  1'b0, ACC_HOLD, WB_INTEG, 1'b0, JMP_NEXT);
      4'd3:  c = mk(OPA_VEL,  OPB_KD,  1'b0, ACC_LOAD, WB_NONE,  1'b0, JMP_NEXT);
      4'd4:  c = mk(OPA_INT,  OPB_KI,  1'b0, ACC_ADD,  WB_NONE,  1'b0, JMP_NEXT);
      4'd5:  c = mk(OPA_VEL,  OPB_SPW, 1'b0, ACC_ADD,  WB_NONE,  1'b0, JMP_NEXT);
      4'd6:  c = mk(OPA_ERR,  OPB_TS,  1'b1, ACC_HOLD, WB_LEVSP, 1'b0, JMP_NEXT);
      4'd7:  c = mk(OPA_ERR,  OPB_KP,  1'b1, ACC_HOLD, WB_INTEG, 1'b1, JMP_NEXT);
      4'd8:  c = mk(OPA_VEL,  OPB_KD,  1'b1, ACC_LOAD, WB_NONE,  1'b1, JMP_NEXT);
      4'd9:  c = mk(OPA_INT,  OPB_KI,  1'b1, ACC_ADD,  WB_NONE,  1'b1, JMP_NEXT);
      4'd10: c = mk(OPA_VEL,  OPB_SPW, 1'b1, ACC_ADD,  WB_NONE,  1'b1, JMP_NEXT);
      4'd11: c = mk(OPA_NONE, OPB_TS,  1'b1, ACC_HOLD, WB_LEVSP, 1'b1, JMP_NEXT);
      4'd12: c = mk(OPA_NONE, OPB_TS,  1'b0, ACC_HOLD, WB_INH,   1'b0, JMP_NEXT);
      4'd13: c = mk(OPA_NONE, OPB_TS,  1'b0, ACC_HOLD, WB_DRV,   1'b0, JMP_WAIT_OUT);
      default: c = mk(OPA_NONE, OPB_TS, 1'b0, ACC_HOLD, WB_NONE, 1'b0, JMP_START);
    endcase
    return c;
  endfunction

endpackage

>>> hdl/ampcc_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module ampcc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  ampcc_pkg::seq_cond_t cond,
  output ampcc_pkg::ctrl_t   ctrl
);
  import ampcc_pkg::*;

  logic [PcW-1:0] pc_r;
  logic [PcW-1:0] pc_nxt;

  assign ctrl = ucode(pc_r);

  always_comb begin
    unique case (ctrl.jmp)
      JMP_NEXT:     pc_nxt = pc_r + 1'b1;
      JMP_WAIT_IN:  pc_nxt = cond.in_go ? pc_r + 1'b1 : pc_r;
      JMP_WAIT_OUT: pc_nxt = cond.out_free ? '0 : pc_r;
      JMP_START:    pc_nxt = '0;
      default:      pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> hdl/antagonist_muscle_pid_cocontraction_unit.sv
// Top level of the antagonist muscle PID co-contraction unit: datapath and registers.
//
// Usage: once per control tick, present the measured right and left muscle
// lengths and velocities on the input channel (in_valid, in_stall). A transfer
// happens at a rising edge with in_valid high and in_stall low. The unit then
// runs a 14-step microprogram on one shared 33x25 multiplier: it updates both
// saturating integrators, forms the two co-contraction levels and spindle
// signals, then the cross-inhibition and the two drive values.
// One result transfer on the output channel (out_valid, out_stall) follows
// every input transfer. The unit takes no new item until the program has
// finished the last one: the multiplier takes five products per muscle, and
// the program adds the inhibition and drive steps.
// The result sits in an output register; while the receiver stalls it holds
// steady, and the program waits in its last step before taking a new item.
// Configuration registers are written through cfg_we, cfg_index, cfg_wdata; the user must
// do so only while the unit is idle, unchecked by the block; unknown-index writes are dropped.
// Synchronous reset (rst_n low) restores the default gains, clears both
// integrators and the output valid flag, holds in_stall high, and returns the program to idle.
module antagonist_muscle_pid_cocontraction_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ampcc_pkg::LenW-1:0]      in_length_right,
  input  logic signed [ampcc_pkg::LenW-1:0]      in_length_left,
  input  logic signed [ampcc_pkg::LenW-1:0]      in_velocity_right,
  input  logic signed [ampcc_pkg::LenW-1:0]      in_velocity_left,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [ampcc_pkg::DriveW-1:0]    out_drive_right,
  output logic        [ampcc_pkg::DriveW-1:0]    out_drive_left,
  input  logic                                   cfg_we,
  input  logic        [ampcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic        [ampcc_pkg::CfgDatW-1:0]   cfg_wdata
);
  import ampcc_pkg::*;

  // Configuration registers.
  logic [TgtW-1:0]  tgt_right_r, tgt_left_r, bias_r;
  logic [TsW-1:0]   timestep_r;
  logic [GainW-1:0] kp_r, kd_r, ki_r;

  // Captured input item.
  logic signed [LenW-1:0] len_right_r, len_left_r, vel_right_r, vel_left_r;

  // Datapath state.
  logic signed [IntegW-1:0] integ_right_r, integ_left_r;
  logic signed [57:0]       prod_r, acc_r;
  logic        [TgtW-1:0]   lev_right_r, lev_left_r;
  logic signed [25:0]       sp_right_r, sp_left_r;
  logic        [26:0]       inh_right_r, inh_left_r;
  logic        [DriveW-1:0] drive_right_r, drive_left_r;
  logic                     out_valid_r;

  ctrl_t     ctrl;
  seq_cond_t cond;

  logic in_go;
  logic out_free;

  // The unit takes an item only in its idle step, and never while reset is held.
  assign in_stall = !rst_n || (ctrl.jmp != JMP_WAIT_IN);
  assign in_go    = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign cond = '{in_go: in_go, out_free: out_free};

  ampcc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl)
  );

  // Length errors: measured minus target, signed Q8.16.
  logic signed [24:0] err_right, err_left;
  assign err_right = {len_right_r[LenW-1], len_right_r} - $signed({2'b00, tgt_right_r});
  assign err_left  = {len_left_r[LenW-1], len_left_r} - $signed({2'b00, tgt_left_r});

  // Multiplier operand selection.
  logic signed [32:0] mul_a_op;
  logic signed [24:0] mul_b_op;
  logic signed [24:0] err_sel;
  logic signed [LenW-1:0] vel_sel;
  logic signed [IntegW-1:0] integ_sel;

  assign err_sel   = ctrl.mul_left ? err_left : err_right;
  assign vel_sel   = ctrl.mul_left ? vel_left_r : vel_right_r;
  assign integ_sel = ctrl.mul_left ? integ_left_r : integ_right_r;

  always_comb begin
    unique case (ctrl.mul_a)
      OPA_ERR:  mul_a_op = {{8{err_sel[24]}}, err_sel};
      OPA_VEL:  mul_a_op = {{9{vel_sel[LenW-1]}}, vel_sel};
      OPA_INT:  mul_a_op = {integ_sel[IntegW-1], integ_sel};
      OPA_NONE: mul_a_op = '0;
      default:  mul_a_op = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.mul_b)
      OPB_TS:  mul_b_op = $signed({1'b0, timestep_r});
      OPB_KP:  mul_b_op = $signed({9'd0, kp_r});
      OPB_KD:  mul_b_op = $signed({9'd0, kd_r});
      OPB_KI:  mul_b_op = $signed({9'd0, ki_r});
      OPB_SPW: mul_b_op = $signed({1'b0, SPINDLE_VEL_WEIGHT});
      default: mul_b_op = '0;
    endcase
  end

  // Integrator update: add the rounded error times timestep and saturate to 32 bits.
  logic signed [57:0]       prod_rnd24;
  logic signed [25:0]       integ_inc;
  logic signed [32:0]       integ_sum;
  logic signed [IntegW-1:0] integ_cur;
  logic signed [IntegW-1:0] integ_nxt;

  assign prod_rnd24 = prod_r + 58'sd8388608;
  assign integ_inc  = prod_rnd24[49:24];
  assign integ_cur  = ctrl.wb_left ? integ_left_r : integ_right_r;
  assign integ_sum  = {integ_cur[IntegW-1], integ_cur} + {{7{integ_inc[25]}}, integ_inc};

  always_comb begin
    if (integ_sum[32] != integ_sum[31]) begin
      integ_nxt = integ_sum[32] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      integ_nxt = integ_sum[IntegW-1:0];
    end
  end

  // Co-contraction level: bias minus the rounded PID sum, clamped to the Q7.16 range.
  logic signed [57:0] acc_rnd;
  logic signed [49:0] pid;
  logic signed [51:0] lev_diff;
  logic        [TgtW-1:0] lev_nxt;

  assign acc_rnd  = acc_r + 58'sd128;
  assign pid      = acc_rnd[57:8];
  assign lev_diff = $signed({29'd0, bias_r}) - {{2{pid[49]}}, pid};

  always_comb begin
    if (lev_diff[51]) begin
      lev_nxt = '0;
    end else if (lev_diff > 52'sd8388607) begin
      lev_nxt = DRIVE_MAX;
    end else begin
      lev_nxt = lev_diff[TgtW-1:0];
    end
  end

  // Spindle signal: length plus the rounded weighted velocity.
  logic signed [57:0]     prod_rnd16;
  logic signed [25:0]     sp_nxt;
  logic signed [LenW-1:0] len_sel_wb;

  assign prod_rnd16 = prod_r + 58'sd32768;
  assign len_sel_wb = ctrl.wb_left ? len_left_r : len_right_r;
  assign sp_nxt     = {{2{len_sel_wb[LenW-1]}}, len_sel_wb} + prod_rnd16[41:16];

  // Cross-inhibition, floored at zero; it never reaches the 32-bit ceiling.
  logic signed [27:0] inh_l_diff, inh_r_diff;

  assign inh_l_diff = {{2{sp_left_r[25]}}, sp_left_r} - {{2{sp_right_r[25]}}, sp_right_r}
                    + $signed({5'd0, lev_right_r}) - $signed({5'd0, lev_left_r});
  assign inh_r_diff = {{2{sp_right_r[25]}}, sp_right_r} - {{2{sp_left_r[25]}}, sp_left_r}
                    + $signed({5'd0, lev_left_r}) - $signed({5'd0, lev_right_r});

  // Drives: spindle minus own level minus the opposing inhibition, clamped.
  logic signed [28:0] drv_r_diff, drv_l_diff;
  logic [DriveW-1:0]  drv_r_nxt, drv_l_nxt;

  assign drv_r_diff = {{3{sp_right_r[25]}}, sp_right_r} - $signed({6'd0, lev_right_r})
                    - $signed({2'd0, inh_left_r});
  assign drv_l_diff = {{3{sp_left_r[25]}}, sp_left_r} - $signed({6'd0, lev_left_r})
                    - $signed({2'd0, inh_right_r});

  always_comb begin
    if (drv_r_diff[28]) begin
      drv_r_nxt = '0;
    end else if (drv_r_diff > 29'sd8388607) begin
      drv_r_nxt = DRIVE_MAX;
    end else begin
      drv_r_nxt = drv_r_diff[DriveW-1:0];
    end
    if (drv_l_diff[28]) begin
      drv_l_nxt = '0;
    end else if (drv_l_diff > 29'sd8388607) begin
      drv_l_nxt = DRIVE_MAX;
    end else begin
      drv_l_nxt = drv_l_diff[DriveW-1:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_right_r <= TGT_RST;
      tgt_left_r  <= TGT_RST;
      timestep_r  <= TIMESTEP_RST;
      kp_r        <= PROP_GAIN_RST;
      kd_r        <= DERIV_GAIN_RST;
      ki_r        <= INTEG_GAIN_RST;
      bias_r      <= BIAS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TGT_RIGHT:  tgt_right_r <= cfg_wdata[TgtW-1:0];
        CFG_TGT_LEFT:   tgt_left_r  <= cfg_wdata[TgtW-1:0];
        CFG_TIMESTEP:   timestep_r  <= cfg_wdata[TsW-1:0];
        CFG_PROP_GAIN:  kp_r        <= cfg_wdata[GainW-1:0];
        CFG_DERIV_GAIN: kd_r        <= cfg_wdata[GainW-1:0];
        CFG_INTEG_GAIN: ki_r        <= cfg_wdata[GainW-1:0];
        CFG_BIAS:       bias_r      <= cfg_wdata[TgtW-1:0];
        default: ;
      endcase
    end
  end

  // Input capture and the shared multiply-accumulate.
  always_ff @(posedge clk) begin
    if (in_go) begin
      len_right_r <= in_length_right;
      len_left_r  <= in_length_left;
      vel_right_r <= in_velocity_right;
      vel_left_r  <= in_velocity_left;
    end
    prod_r <= mul_a_op * mul_b_op;
    unique case (ctrl.acc_op)
      ACC_LOAD: acc_r <= prod_r;
      ACC_ADD:  acc_r <= acc_r + prod_r;
      ACC_HOLD: acc_r <= acc_r;
      default:  acc_r <= acc_r;
    endcase
  end

  // Write-back of per-muscle results, the final inhibition terms and the drive values.
  always_ff @(posedge clk) begin
    if (ctrl.wb == WB_LEVSP) begin
      if (ctrl.wb_left) begin
        lev_left_r <= lev_nxt;
        sp_left_r  <= sp_nxt;
      end else begin
        lev_right_r <= lev_nxt;
        sp_right_r  <= sp_nxt;
      end
    end
    if (ctrl.wb == WB_INH) begin
      inh_left_r  <= inh_l_diff[27] ? 27'd0 : inh_l_diff[26:0];
      inh_right_r <= inh_r_diff[27] ? 27'd0 : inh_r_diff[26:0];
    end
    if (ctrl.wb == WB_DRV && out_free) begin
      drive_right_r <= drv_r_nxt;
      drive_left_r  <= drv_l_nxt;
    end
  end

  // Integrators and the output valid flag are control state and reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_right_r <= '0;
      integ_left_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (ctrl.wb == WB_INTEG) begin
        if (ctrl.wb_left) begin
          integ_left_r <= integ_nxt;
        end else begin
          integ_right_r <= integ_nxt;
        end
      end
      if (ctrl.wb == WB_DRV && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive_right = drive_right_r;
  assign out_drive_left  = drive_left_r;

endmodule

>>> tb/sv/antagonist_muscle_pid_cocontraction_unit_tb.sv
// Self-checking testbench for the antagonist muscle PID co-contraction unit.
`timescale 1ns / 1ps

module antagonist_muscle_pid_cocontraction_unit_tb;
  import ampcc_pkg::*;

  // Half of the 20 ns clock period.
  localparam int ClkHalf = 10;
  localparam int ResetCycles = 8;
  // Long receiver hold-off, far longer than one pass of the microprogram.
  localparam int HoldOffCycles = 400;
  // Cycles without any transfer before the run is declared hung. This covers
  // the long hold-off plus a full pass of the block and a sender gap, with margin.
  localparam int IdleLimit = 2000;
  // Settling time after the last result.
  localparam int DrainCycles = 40;
  localparam int ReportLimit = 10;

  // The unit decodes indexes 0 to 6; this one must be dropped.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

  localparam longint Int32Hi = 64'sd2147483647;
  localparam longint Int32Lo = -64'sd2147483648;

  typedef logic signed [LenW-1:0] len_t;

  localparam len_t LenMax = 24'sh7FFFFF;
  localparam len_t LenMin = 24'sh800000;

  typedef struct packed {
    logic [DriveW-1:0] right;
    logic [DriveW-1:0] left;
  } drive_pair_t;

  // Keeps its own copy of the registers and both integrators, works out the
  // drive pair for every accepted tick and compares the returned drives in order.
  class drive_scoreboard;
    longint tgt_right, tgt_left, timestep, kp, kd, ki, bias;
    longint integ_right, integ_left;
    drive_pair_t expected_drives[$];
    int faults;

    function new();
      tgt_right   = longint'(TGT_RST);
      tgt_left    = longint'(TGT_RST);
      timestep    = longint'(TIMESTEP_RST);
      kp          = longint'(PROP_GAIN_RST);
      kd          = longint'(DERIV_GAIN_RST);
      ki          = longint'(INTEG_GAIN_RST);
      bias        = longint'(BIAS_RST);
      integ_right = 0;
      integ_left  = 0;
      faults      = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      case (idx)
        CFG_TGT_RIGHT:  tgt_right = longint'(data[TgtW-1:0]);
        CFG_TGT_LEFT:   tgt_left  = longint'(data[TgtW-1:0]);
        CFG_TIMESTEP:   timestep  = longint'(data[TsW-1:0]);
        CFG_PROP_GAIN:  kp        = longint'(data[GainW-1:0]);
        CFG_DERIV_GAIN: kd        = longint'(data[GainW-1:0]);
        CFG_INTEG_GAIN: ki        = longint'(data[GainW-1:0]);
        CFG_BIAS:       bias      = longint'(data[TgtW-1:0]);
        default: ;
      endcase
    endfunction

    // Round to nearest, ties toward plus infinity; >>> on a longint floors.
    function longint rescale(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint limit(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
    endfunction

    function longint level(longint err, longint vel, longint integ);
      longint acc;
      acc = kp * err + kd * vel + ki * integ;
      return limit(bias - rescale(acc, 8), 0, longint'(DRIVE_MAX));
    endfunction

    function longint spindle(longint len, longint vel);
      return len + rescale(longint'(SPINDLE_VEL_WEIGHT) * vel, 16);
    endfunction

    function void note_tick(len_t len_r, len_t len_l, len_t vel_r, len_t vel_l);
      longint lr, ll, vr, vl, err_r, err_l, lev_r, lev_l, sp_r, sp_l, inh_r, inh_l;
      drive_pair_t d;
      lr = longint'(len_r);
      ll = longint'(len_l);
      vr = longint'(vel_r);
      vl = longint'(vel_l);
      err_r = lr - tgt_right;
      err_l = ll - tgt_left;
      integ_right = limit(integ_right + rescale(err_r * timestep, 24), Int32Lo, Int32Hi);
      integ_left  = limit(integ_left + rescale(err_l * timestep, 24), Int32Lo, Int32Hi);
      lev_r = level(err_r, vr, integ_right);
      lev_l = level(err_l, vl, integ_left);
      sp_r  = spindle(lr, vr);
      sp_l  = spindle(ll, vl);
      inh_l = limit(sp_l - sp_r + (lev_r - lev_l), 0, Int32Hi);
      inh_r = limit(sp_r - sp_l + (lev_l - lev_r), 0, Int32Hi);
      d.right = DriveW'(limit(sp_r - lev_r - inh_l, 0, longint'(DRIVE_MAX)));
      d.left  = DriveW'(limit(sp_l - lev_l - inh_r, 0, longint'(DRIVE_MAX)));
      expected_drives = {expected_drives, d};
    endfunction

    function void check_drive(logic [DriveW-1:0] right, logic [DriveW-1:0] left);
      drive_pair_t want;
      if (expected_drives.size() == 0) begin
        faults++;
        if (faults <= ReportLimit)
          $display("%0t: drive transfer with nothing expected: right=%0d left=%0d",
                   $time, right, left);
        return;
      end
      want = expected_drives.pop_front();
      if (want.right !== right || want.left !== left) begin
        faults++;
        if (faults <= ReportLimit)
          $display("%0t: drive mismatch: expected right=%0d left=%0d, got right=%0d left=%0d",
                   $time, want.right, want.left, right, left);
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  len_t                in_length_right;
  len_t                in_length_left;
  len_t                in_velocity_right;
  len_t                in_velocity_left;
  logic                out_valid;
  logic                out_stall;
  logic [DriveW-1:0]   out_drive_right;
  logic [DriveW-1:0]   out_drive_left;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDatW-1:0]  cfg_wdata;

  drive_scoreboard sb;
  // Set for the closing part of the run: neither side idles any more.
  bit calm;
  // Asks the receiver process for one long hold-off; it clears the flag when done.
  bit hold_off_req;

  antagonist_muscle_pid_cocontraction_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_length_right   (in_length_right),
    .in_length_left    (in_length_left),
    .in_velocity_right (in_velocity_right),
    .in_velocity_left  (in_velocity_left),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_right   (out_drive_right),
    .out_drive_left    (out_drive_left),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #ClkHalf clk = ~clk;

  // Offers one tick at the falling edge and holds it until a rising edge sees
  // the stall low. The payload stays put while the unit stalls. Valid is left
  // high afterwards, so back-to-back ticks never lower and raise it in one step.
  task automatic send_tick(len_t len_r, len_t len_l, len_t vel_r, len_t vel_l);
    @(negedge clk);
    in_valid          <= 1'b1;
    in_length_right   <= len_r;
    in_length_left    <= len_l;
    in_velocity_right <= vel_r;
    in_velocity_left  <= vel_l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(len_r, len_l, vel_r, vel_l);
  endtask

  // Drops valid for a gap whose length the caller gives.
  task automatic pause_sender(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stops offering and waits until every tick has produced its drive transfer.
  // Every tick yields exactly one result, so the unit is idle once the last
  // one has been taken; the task still lets the clock run on before it returns.
  task automatic drain();
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write per cycle; the caller lowers the write enable after the
  // last one, so the enable never gets two assignments in one step.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
  endtask

  task automatic load_settings(logic [CfgDatW-1:0] tgt_r, logic [CfgDatW-1:0] tgt_l,
                               logic [CfgDatW-1:0] ts, logic [CfgDatW-1:0] p_gain,
                               logic [CfgDatW-1:0] d_gain, logic [CfgDatW-1:0] i_gain,
                               logic [CfgDatW-1:0] co_bias);
    write_reg(CFG_TGT_RIGHT, tgt_r);
    write_reg(CFG_TGT_LEFT, tgt_l);
    write_reg(CFG_TIMESTEP, ts);
    write_reg(CFG_PROP_GAIN, p_gain);
    write_reg(CFG_DERIV_GAIN, d_gain);
    write_reg(CFG_INTEG_GAIN, i_gain);
    write_reg(CFG_BIAS, co_bias);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix of field extremes, full-range values and small values around zero,
  // where the drives are neither floored nor saturated most often.
  function automatic len_t any_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return LenMax;
          1: return LenMin;
          2: return len_t'(0);
          3: return len_t'(-1);
          default: return len_t'(1);
        endcase
      end
      1, 2, 3: return len_t'($urandom());
      default: return len_t'(int'($urandom_range(0, 32'h80000)) - 32'sh40000);
    endcase
  endfunction

  // A nonzero lean pins lengths near one end of the range so that the length
  // error keeps its sign and drives an integrator into saturation.
  function automatic len_t lean_length(int lean);
    if (lean > 0) return LenMax - len_t'($urandom_range(0, 65535));
    if (lean < 0) return LenMin + len_t'($urandom_range(0, 65535));
    return any_value();
  endfunction

  // One stretch of random ticks under fixed settings. With hold set, a long
  // receiver hold-off is requested a third of the way in; the sender keeps
  // offering without gaps meanwhile, so the unit fills up and stalls its input.
  task automatic run_phase(int count, int lean, bit hold);
    for (int i = 0; i < count; i++) begin
      if (hold && i == count / 3) hold_off_req = 1'b1;
      send_tick(lean_length(lean), lean_length(lean), any_value(), any_value());
      if (!calm && !hold_off_req && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 11));
    end
    drain();
  endtask

  function automatic logic [CfgDatW-1:0] any_reg();
    return CfgDatW'($urandom());
  endfunction

  // Receiver side: random stall bursts between free-running stretches, the
  // requested long hold-off, and no stalls at all once calm.
  // The stall is changed only at falling edges, once per step.
  initial begin
    int cycles;
    logic level_now;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HoldOffCycles - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (calm) begin
          level_now = 1'b0;
          cycles = 1;
        end else if ($urandom_range(0, 2) == 0) begin
          level_now = 1'b1;
          cycles = $urandom_range(1, 11);
        end else begin
          level_now = 1'b0;
          cycles = $urandom_range(1, 30);
        end
        out_stall <= level_now;
        repeat (cycles - 1) @(negedge clk);
      end
    end
  end

  // Every drive transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_drive(out_drive_right, out_drive_left);
  end

  // Watchdog: ends the run if no transfer happens on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new();
    calm              = 1'b0;
    hold_off_req      = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_length_right   = '0;
    in_length_left    = '0;
    in_velocity_right = '0;
    in_velocity_left  = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_TGT_RIGHT;
    cfg_wdata         = '0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // A write to an index the unit does not decode must change nothing.
    write_reg(CFG_UNUSED, any_reg());
    @(negedge clk);
    cfg_we <= 1'b0;

    // Directed ticks under the reset settings: field extremes in both
    // directions, opposite muscles pulled apart, and values around zero.
    // All lengths at the top give a saturated drive; all at the bottom give
    // a large, clamped co-contraction level.
    send_tick(len_t'(0), len_t'(0), len_t'(0), len_t'(0));
    send_tick(LenMax, LenMax, LenMax, LenMax);
    send_tick(LenMin, LenMin, LenMin, LenMin);
    send_tick(LenMax, LenMax, LenMin, LenMin);
    send_tick(LenMin, LenMin, LenMax, LenMax);
    send_tick(LenMax, LenMin, len_t'(0), len_t'(0));
    send_tick(LenMin, LenMax, len_t'(0), len_t'(0));
    send_tick(len_t'(0), len_t'(0), LenMax, LenMin);
    send_tick(len_t'(0), len_t'(0), LenMin, LenMax);
    send_tick(len_t'(-1), len_t'(-1), len_t'(-1), len_t'(-1));
    send_tick(len_t'(1), len_t'(1), len_t'(1), len_t'(1));
    send_tick(len_t'(32'h10000), len_t'(32'h10000), len_t'(0), len_t'(0));
    send_tick(len_t'(32'h18000), len_t'(32'h8000), len_t'(32'h4000), len_t'(-32'sh4000));
    send_tick(len_t'(32'h400000), len_t'(32'h1000), len_t'(-32'sh20000), len_t'(32'h20000));
    send_tick(len_t'(32'h1000), len_t'(32'h400000), len_t'(32'h20000), len_t'(-32'sh20000));
    send_tick(len_t'(32'h555555), len_t'(32'h2AAAAA), len_t'(32'hAAAAAA), len_t'(32'hD55555));
    drain();

    // Timestep near one second, targets at zero, lengths near the top: the
    // integrators climb until they saturate at the positive limit.
    load_settings('0, '0, 24'hFFFFFF, CfgDatW'($urandom_range(0, 16'h0400)),
                  CfgDatW'($urandom_range(0, 16'h0400)), CfgDatW'($urandom_range(0, 16'h0040)),
                  any_reg());
    run_phase(330, 1, 1'b0);

    // Every register at its largest value, lengths near the bottom: the
    // integrators swing down to the negative limit and the level clamps high.
    load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                  24'hFFFFFF);
    run_phase(300, -1, 1'b0);

    // Fully random settings, including the long receiver hold-off.
    load_settings(any_reg(), any_reg(), any_reg(), any_reg(), any_reg(), any_reg(), any_reg());
    run_phase(250, 0, 1'b1);

    // Every register at zero.
    load_settings('0, '0, '0, '0, '0, '0, '0);
    run_phase(120, 0, 1'b0);

    // Settings in the range a real controller would use.
    load_settings(CfgDatW'($urandom_range(32'h8000, 32'h40000)),
                  CfgDatW'($urandom_range(32'h8000, 32'h40000)),
                  CfgDatW'($urandom_range(0, 32'h20000)),
                  CfgDatW'($urandom_range(0, 32'h3000)),
                  CfgDatW'($urandom_range(0, 32'h3000)),
                  CfgDatW'($urandom_range(0, 32'h3000)),
                  CfgDatW'($urandom_range(0, 32'h40000)));
    run_phase(280, 0, 1'b0);

    load_settings(any_reg(), any_reg(), any_reg(), any_reg(), any_reg(), any_reg(), any_reg());
    run_phase(200, 0, 1'b0);

    // Closing stretch at full rate on both sides.
    calm = 1'b1;
    load_settings(any_reg(), any_reg(), CfgDatW'($urandom_range(0, 32'h20000)),
                  CfgDatW'($urandom_range(0, 32'h3000)), CfgDatW'($urandom_range(0, 32'h3000)),
                  CfgDatW'($urandom_range(0, 32'h3000)), any_reg());
    run_phase(200, 0, 1'b0);

    repeat (DrainCycles) @(posedge clk);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ampcc_pkg.sv
hdl/ampcc_seq.sv
hdl/antagonist_muscle_pid_cocontraction_unit.sv
tb/sv/antagonist_muscle_pid_cocontraction_unit_tb.sv
